// ===== rtl/rtc_pkg.sv =====
`default_nettype none
package rtc_pkg;

    localparam int QW             = 64;
    localparam int DIST_W         = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int RF_DEPTH       = 64;
    localparam int RF_AW          = 6;
    localparam int PC_W           = 7;
    localparam int LD_W           = 5;

    localparam logic signed [QW-1:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR   = 3'd7;

    // register file map
    localparam logic [RF_AW-1:0] RA_A   = 6'd0;
    localparam logic [RF_AW-1:0] RA_B   = 6'd3;
    localparam logic [RF_AW-1:0] RA_C   = 6'd6;
    localparam logic [RF_AW-1:0] RA_O   = 6'd9;
    localparam logic [RF_AW-1:0] RA_D   = 6'd12;
    localparam logic [RF_AW-1:0] RA_NL  = 6'd15;
    localparam logic [RF_AW-1:0] RA_FL  = 6'd16;
    localparam logic [RF_AW-1:0] RA_E1  = 6'd17;
    localparam logic [RF_AW-1:0] RA_E2  = 6'd20;
    localparam logic [RF_AW-1:0] RA_N   = 6'd23;
    localparam logic [RF_AW-1:0] RA_DEN = 6'd26;
    localparam logic [RF_AW-1:0] RA_W   = 6'd27;
    localparam logic [RF_AW-1:0] RA_NUM = 6'd30;
    localparam logic [RF_AW-1:0] RA_T   = 6'd31;
    localparam logic [RF_AW-1:0] RA_P   = 6'd32;
    localparam logic [RF_AW-1:0] RA_H   = 6'd33;
    localparam logic [RF_AW-1:0] RA_F   = 6'd36;
    localparam logic [RF_AW-1:0] RA_G   = 6'd39;
    localparam logic [RF_AW-1:0] RA_X   = 6'd42;
    localparam logic [RF_AW-1:0] RA_DV  = 6'd45;
    localparam logic [RF_AW-1:0] RA_D2  = 6'd48;
    localparam logic [RF_AW-1:0] RA_LO2 = 6'd49;
    localparam logic [RF_AW-1:0] RA_HI2 = 6'd50;
    localparam logic [RF_AW-1:0] RA_SCR = 6'd51;

    localparam logic [LD_W-1:0] LD_LAST = 5'd16;

    typedef enum logic [3:0] {
        OP_SUB, OP_ADD, OP_MUL, OP_MADD, OP_MSUB, OP_DIV,
        OP_BRNEG, OP_BRNNEG, OP_BRPOS, OP_CMP, OP_END
    } t_opc;

    typedef struct packed {
        t_opc             opc;
        logic [RF_AW-1:0] a;
        logic [RF_AW-1:0] b;
        logic [RF_AW-1:0] d;
    } t_uop;

    function automatic logic signed [QW-1:0] sat_add(logic signed [QW-1:0] a,
                                                     logic signed [QW-1:0] b);
        logic signed [QW:0] s;
        logic signed [QW:0] lim;
        s   = {a[QW-1], a} + {b[QW-1], b};
        lim = {1'b0, SAT_LIM};
        if (s > lim) return SAT_LIM;
        if (s < -lim) return -SAT_LIM;
        return s[QW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] sat_sub(logic signed [QW-1:0] a,
                                                     logic signed [QW-1:0] b);
        logic signed [QW:0] s;
        logic signed [QW:0] lim;
        s   = {a[QW-1], a} - {b[QW-1], b};
        lim = {1'b0, SAT_LIM};
        if (s > lim) return SAT_LIM;
        if (s < -lim) return -SAT_LIM;
        return s[QW-1:0];
    endfunction

    function automatic t_uop mk(t_opc o, logic [RF_AW-1:0] a, logic [RF_AW-1:0] b,
                                logic [RF_AW-1:0] d);
        t_uop u;
        u.opc = o;
        u.a   = a;
        u.b   = b;
        u.d   = d;
        return u;
    endfunction

    function automatic t_uop sub3(logic [1:0] k, logic [RF_AW-1:0] u, logic [RF_AW-1:0] v,
                                  logic [RF_AW-1:0] d);
        logic [RF_AW-1:0] o;
        o = RF_AW'(k);
        return mk(OP_SUB, u + o, v + o, d + o);
    endfunction

    function automatic t_uop cross6(logic [2:0] k, logic [RF_AW-1:0] u,
                                    logic [RF_AW-1:0] v, logic [RF_AW-1:0] d);
        t_uop r;
        case (k)
            3'd0:    r = mk(OP_MUL,  u + 6'd1, v + 6'd2, RA_SCR);
            3'd1:    r = mk(OP_MSUB, u + 6'd2, v + 6'd1, d);
            3'd2:    r = mk(OP_MUL,  u + 6'd2, v,        RA_SCR);
            3'd3:    r = mk(OP_MSUB, u,        v + 6'd2, d + 6'd1);
            3'd4:    r = mk(OP_MUL,  u,        v + 6'd1, RA_SCR);
            default: r = mk(OP_MSUB, u + 6'd1, v,        d + 6'd2);
        endcase
        return r;
    endfunction

    function automatic t_uop dot3(logic [1:0] k, logic [RF_AW-1:0] u, logic [RF_AW-1:0] v,
                                  logic [RF_AW-1:0] d);
        t_uop r;
        case (k)
            2'd0:    r = mk(OP_MUL,  u,        v,        RA_SCR);
            2'd1:    r = mk(OP_MADD, u + 6'd1, v + 6'd1, RA_SCR);
            default: r = mk(OP_MADD, u + 6'd2, v + 6'd2, d);
        endcase
        return r;
    endfunction

    function automatic t_uop edge_uop(logic [3:0] s, logic [RF_AW-1:0] f,
                                      logic [RF_AW-1:0] t);
        logic [3:0] j;
        t_uop       r;
        if (s < 4'd3) begin
            r = sub3(s[1:0], t, f, RA_F);
        end else if (s < 4'd6) begin
            j = s - 4'd3;
            r = sub3(j[1:0], RA_H, f, RA_G);
        end else if (s < 4'd12) begin
            j = s - 4'd6;
            r = cross6(j[2:0], RA_F, RA_G, RA_X);
        end else if (s < 4'd15) begin
            j = s - 4'd12;
            r = dot3(j[1:0], RA_X, RA_N, RA_SCR);
        end else begin
            r = mk(OP_BRPOS, RA_SCR, RA_SCR, RA_SCR);
        end
        return r;
    endfunction

    function automatic t_uop uop_at(logic [PC_W-1:0] pc);
        logic [PC_W-1:0]  j;
        logic [RF_AW-1:0] f;
        logic [RF_AW-1:0] t;
        t_uop             r;
        if (pc < 7'd3) begin
            r = sub3(pc[1:0], RA_B, RA_A, RA_E1);
        end else if (pc < 7'd6) begin
            j = pc - 7'd3;
            r = sub3(j[1:0], RA_C, RA_A, RA_E2);
        end else if (pc < 7'd12) begin
            j = pc - 7'd6;
            r = cross6(j[2:0], RA_E1, RA_E2, RA_N);
        end else if (pc < 7'd15) begin
            j = pc - 7'd12;
            r = dot3(j[1:0], RA_N, RA_D, RA_DEN);
        end else if (pc == 7'd15) begin
            r = mk(OP_BRNEG, RA_DEN, RA_DEN, RA_DEN);
        end else if (pc < 7'd19) begin
            j = pc - 7'd16;
            r = sub3(j[1:0], RA_O, RA_A, RA_W);
        end else if (pc < 7'd22) begin
            j = pc - 7'd19;
            r = dot3(j[1:0], RA_W, RA_N, RA_NUM);
        end else if (pc == 7'd22) begin
            r = mk(OP_DIV, RA_NUM, RA_DEN, RA_T);
        end else if (pc == 7'd23) begin
            r = mk(OP_BRNNEG, RA_T, RA_T, RA_T);
        end else if (pc < 7'd30) begin
            j = pc - 7'd24;
            if (j[0] == 1'b0) begin
                r = mk(OP_MUL, RA_T, RA_D + RF_AW'(j[2:1]), RA_P);
            end else begin
                r = mk(OP_ADD, RA_O + RF_AW'(j[2:1]), RA_P, RA_H + RF_AW'(j[2:1]));
            end
        end else if (pc < 7'd78) begin
            j = pc - 7'd30;
            case (j[5:4])
                2'd0: begin
                    f = RA_A;
                    t = RA_B;
                end
                2'd1: begin
                    f = RA_B;
                    t = RA_C;
                end
                default: begin
                    f = RA_C;
                    t = RA_A;
                end
            endcase
            r = edge_uop(j[3:0], f, t);
        end else if (pc < 7'd81) begin
            j = pc - 7'd78;
            r = sub3(j[1:0], RA_O, RA_H, RA_DV);
        end else if (pc < 7'd84) begin
            j = pc - 7'd81;
            r = dot3(j[1:0], RA_DV, RA_DV, RA_D2);
        end else if (pc == 7'd84) begin
            r = mk(OP_MUL, RA_NL, RA_NL, RA_LO2);
        end else if (pc == 7'd85) begin
            r = mk(OP_MUL, RA_FL, RA_FL, RA_HI2);
        end else if (pc == 7'd86) begin
            r = mk(OP_CMP, RA_D2, RA_LO2, RA_SCR);
        end else begin
            r = mk(OP_END, RA_SCR, RA_SCR, RA_SCR);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rtc_tri_if.sv =====
`default_nettype none
interface rtc_tri_if import rtc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic                         last_triangle;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    last_triangle, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  last_triangle, output ready);
endinterface
`default_nettype wire

// ===== rtl/rtc_res_if.sv =====
`default_nettype none
interface rtc_res_if import rtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit_found;
    logic [DIST_W-1:0] hit_range;

    modport source (output valid, hit_found, hit_range, input ready);
    modport sink (input valid, hit_found, hit_range, output ready);
endinterface
`default_nettype wire

// ===== rtl/ray_triangle_closest_hit_core.sv =====
// Closest-hit ray/triangle test over a run of triangles, signed fixed point.
// Configuration: write ray origin, direction and the near/far window through
// i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
// Input channel i_tri: one triangle (three vertices) per transfer; the transfer
// with last_triangle set closes the run. Output channel o_res: one transfer per
// run carrying hit_found and the floor square root of the nearest squared hit
// distance, zero when nothing was hit and all ones when it saturates.
// A two-entry queue takes triangles while the back end works. Each triangle is
// loaded into the register file with the ray configuration and then stepped
// through a micro-sequence on one shared multi-cycle multiplier and a
// bit-serial divider; a back-facing triangle ends at the denominator check,
// and others may run on to the distance compare. The last triangle of a run
// adds a square root step. The result waits in an output register; a stalled
// receiver holds it, and the back end stalls only when a second result is
// ready before the first has been taken. Reset clears the queue, the run
// state and the ray configuration registers.
`default_nettype none
module ray_triangle_closest_hit_core import rtc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    rtc_tri_if.sink                    i_tri,
    rtc_res_if.source                  o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0] i_cfg_data
);
    localparam int DW = 9 * COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] r_org_x, r_org_y, r_org_z;
    logic signed [COORD_BITS-1:0] r_dir_x, r_dir_y, r_dir_z;
    logic [COORD_BITS-2:0]        r_near, r_far;
    logic [DW-1:0]                in_data;
    logic                         q_valid, q_ready;
    logic [DW-1:0]                q_data;

    assign in_data = {i_tri.last_triangle, i_tri.c_z, i_tri.c_y, i_tri.c_x,
                      i_tri.b_z, i_tri.b_y, i_tri.b_x, i_tri.a_z, i_tri.a_y, i_tri.a_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= '0;
            r_near  <= '0;
            r_far   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORG_X: r_org_x <= i_cfg_data;
                CFG_ORG_Y: r_org_y <= i_cfg_data;
                CFG_ORG_Z: r_org_z <= i_cfg_data;
                CFG_DIR_X: r_dir_x <= i_cfg_data;
                CFG_DIR_Y: r_dir_y <= i_cfg_data;
                CFG_DIR_Z: r_dir_z <= i_cfg_data;
                CFG_NEAR:  r_near  <= i_cfg_data[COORD_BITS-2:0];
                CFG_FAR:   r_far   <= i_cfg_data[COORD_BITS-2:0];
                default: ;
            endcase
        end
    end

    rtc_front #(.DW(DW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_tri.valid), .o_ready(i_tri.ready), .i_data(in_data),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    rtc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_data(q_data),
        .i_org_x(r_org_x), .i_org_y(r_org_y), .i_org_z(r_org_z),
        .i_dir_x(r_dir_x), .i_dir_y(r_dir_y), .i_dir_z(r_dir_z),
        .i_near(r_near), .i_far(r_far),
        .o_res_valid(o_res.valid), .i_res_ready(o_res.ready),
        .o_hit_found(o_res.hit_found), .o_hit_range(o_res.hit_range)
    );
endmodule
`default_nettype wire

// ===== rtl/rtc_ram.sv =====
`default_nettype none
module rtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/rtc_front.sv =====
`default_nettype none
module rtc_front #(
    parameter int DW = 289
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [DW-1:0] i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic      [DW-1:0] o_data
);
    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rtc_mul.sv =====
`default_nettype none
module rtc_mul import rtc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [QW-1:0] i_a,
    input  wire logic signed [QW-1:0] i_b,
    output logic                      o_done,
    output logic signed [QW-1:0]      o_p
);
    logic              r_busy;
    logic              r_fin;
    logic [1:0]        r_k;
    logic [QW-1:0]     r_ma;
    logic [QW-1:0]     r_mb;
    logic              r_neg;
    logic [2*QW-1:0]   r_acc;
    logic [QW/2-1:0]   ha;
    logic [QW/2-1:0]   hb;
    logic [QW-1:0]     part;
    logic [2*QW-1:0]   shifted;
    logic [QW-1:0]     mag;

    always_comb begin
        ha   = r_k[1] ? r_ma[QW-1:QW/2] : r_ma[QW/2-1:0];
        hb   = r_k[0] ? r_mb[QW-1:QW/2] : r_mb[QW/2-1:0];
        part = ha * hb;
        case (r_k)
            2'd0:    shifted = {{QW{1'b0}}, part};
            2'd3:    shifted = {part, {QW{1'b0}}};
            default: shifted = {{(QW/2){1'b0}}, part, {(QW/2){1'b0}}};
        endcase
        mag = r_acc[QW+FRAC_BITS-1:FRAC_BITS];
        if ((|r_acc[2*QW-1:QW+FRAC_BITS]) || (mag > QW'(SAT_LIM))) begin
            mag = QW'(SAT_LIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy && !r_fin) begin
                if (r_k == 2'd3) r_fin <= 1'b1;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[QW-1] ? QW'(-i_a) : QW'(i_a);
            r_mb  <= i_b[QW-1] ? QW'(-i_b) : QW'(i_b);
            r_neg <= i_a[QW-1] ^ i_b[QW-1];
            r_acc <= '0;
            r_k   <= 2'd0;
        end else if (r_busy && !r_fin) begin
            r_acc <= r_acc + shifted;
            r_k   <= r_k + 2'd1;
        end
        if (r_fin) begin
            o_p <= r_neg ? -$signed(mag) : $signed(mag);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rtc_div.sv =====
`default_nettype none
module rtc_div import rtc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [QW-1:0] i_x,
    input  wire logic signed [QW-1:0] i_y,
    output logic                      o_done,
    output logic signed [QW-1:0]      o_q
);
    logic            r_busy;
    logic            r_fin;
    logic [6:0]      r_cnt;
    logic [2*QW-1:0] r_dvd;
    logic [QW-1:0]   r_rem;
    logic [QW-1:0]   r_q;
    logic [QW-1:0]   r_d;
    logic            r_over;
    logic            r_neg;
    logic [QW-1:0]   rem_sh;
    logic            qb;
    logic [QW-1:0]   mag;
    logic [QW-1:0]   ax;

    always_comb begin
        rem_sh = {r_rem[QW-2:0], r_dvd[2*QW-1]};
        qb     = (rem_sh >= r_d);
        mag    = r_over ? '1 : r_q;
        if (mag > QW'(SAT_LIM)) mag = QW'(SAT_LIM);
        if (r_d == '0) mag = '0;
        ax     = i_x[QW-1] ? QW'(-i_x) : QW'(i_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy && !r_fin) begin
                if (r_cnt == 7'd127) r_fin <= 1'b1;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {{QW{1'b0}}, ax} << FRAC_BITS;
            r_d    <= i_y[QW-1] ? QW'(-i_y) : QW'(i_y);
            r_neg  <= i_x[QW-1] ^ i_y[QW-1];
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy && !r_fin) begin
            r_rem  <= qb ? rem_sh - r_d : rem_sh;
            r_over <= r_over | r_q[QW-1];
            r_q    <= {r_q[QW-2:0], qb};
            r_dvd  <= r_dvd << 1;
            r_cnt  <= r_cnt + 7'd1;
        end
        if (r_fin) begin
            o_q <= r_neg ? -$signed(mag) : $signed(mag);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rtc_sqrt.sv =====
`default_nettype none
module rtc_sqrt import rtc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [QW-1:0]     i_x,
    output logic                   o_done,
    output logic      [DIST_W-1:0] o_r
);
    logic          r_busy;
    logic [4:0]    r_cnt;
    logic [QW-1:0] r_x;
    logic [QW-1:0] r_res;
    logic [QW-1:0] r_bit;
    logic [QW-1:0] trial;

    assign trial = r_res + r_bit;
    assign o_r   = r_res[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= QW'(1) << (QW - 2);
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 5'd1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rtc_back.sv =====
`default_nettype none
module rtc_back import rtc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DW         = 9 * COORD_BITS + 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    output logic                              o_q_ready,
    input  wire logic [DW-1:0]                i_q_data,
    input  wire logic signed [COORD_BITS-1:0] i_org_x,
    input  wire logic signed [COORD_BITS-1:0] i_org_y,
    input  wire logic signed [COORD_BITS-1:0] i_org_z,
    input  wire logic signed [COORD_BITS-1:0] i_dir_x,
    input  wire logic signed [COORD_BITS-1:0] i_dir_y,
    input  wire logic signed [COORD_BITS-1:0] i_dir_z,
    input  wire logic [COORD_BITS-2:0]        i_near,
    input  wire logic [COORD_BITS-2:0]        i_far,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output logic                              o_hit_found,
    output logic [DIST_W-1:0]                 o_hit_range
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_FETCH = 6'b000100,
        S_EXEC  = 6'b001000,
        S_SQRT  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [LD_W-1:0]       r_ld, n_ld;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic                  r_busy, n_busy;
    logic signed [QW-1:0]  r_acc, n_acc;
    logic                  r_last, n_last;
    logic [QW-1:0]         r_best, n_best;
    logic                  r_any, n_any;
    logic                  r_out_valid, n_out_valid;
    logic                  r_hit, n_hit;
    logic [DIST_W-1:0]     r_dist, n_dist;

    t_uop                  uop;
    logic                  we;
    logic [RF_AW-1:0]      waddr;
    logic signed [QW-1:0]  wdata;
    logic [QW-1:0]         rd_a_raw, rd_b_raw;
    logic signed [QW-1:0]  rd_a, rd_b;
    logic signed [QW-1:0]  ld_val;
    logic [COORD_BITS-1:0] vtx;
    logic                  adv, fin;
    logic                  mul_start, mul_done;
    logic signed [QW-1:0]  mul_p;
    logic                  div_start, div_done;
    logic signed [QW-1:0]  div_q;
    logic                  sqrt_start, sqrt_done;
    logic [DIST_W-1:0]     sqrt_r;
    logic signed [QW-1:0]  mac;

    function automatic logic signed [QW-1:0] sx(logic [COORD_BITS-1:0] v);
        return {{(QW-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    assign uop  = uop_at(r_pc);
    assign rd_a = rd_a_raw;
    assign rd_b = rd_b_raw;

    rtc_ram #(.WIDTH(QW), .DEPTH(RF_DEPTH)) u_rf_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(uop.a), .o_rdata(rd_a_raw)
    );

    rtc_ram #(.WIDTH(QW), .DEPTH(RF_DEPTH)) u_rf_b (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(uop.b), .o_rdata(rd_b_raw)
    );

    rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(rd_a), .i_b(rd_b), .o_done(mul_done), .o_p(mul_p)
    );

    rtc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_x(-rd_a), .i_y(rd_b), .o_done(div_done), .o_q(div_q)
    );

    rtc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_x(r_best << FRAC_BITS), .o_done(sqrt_done), .o_r(sqrt_r)
    );

    always_comb begin
        vtx = i_q_data[r_ld[3:0]*COORD_BITS +: COORD_BITS];
        case (r_ld)
            5'd9:    ld_val = sx(i_org_x);
            5'd10:   ld_val = sx(i_org_y);
            5'd11:   ld_val = sx(i_org_z);
            5'd12:   ld_val = sx(i_dir_x);
            5'd13:   ld_val = sx(i_dir_y);
            5'd14:   ld_val = sx(i_dir_z);
            5'd15:   ld_val = QW'(i_near);
            5'd16:   ld_val = QW'(i_far);
            default: ld_val = sx(vtx);
        endcase
    end

    always_comb begin
        case (uop.opc)
            OP_MADD: mac = sat_add(r_acc, mul_p);
            OP_MSUB: mac = sat_sub(r_acc, mul_p);
            default: mac = mul_p;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_ld        = r_ld;
        n_pc        = r_pc;
        n_busy      = r_busy;
        n_acc       = r_acc;
        n_last      = r_last;
        n_best      = r_best;
        n_any       = r_any;
        n_out_valid = r_out_valid && !i_res_ready;
        n_hit       = r_hit;
        n_dist      = r_dist;
        we          = 1'b0;
        waddr       = uop.d;
        wdata       = mac;
        o_q_ready   = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        sqrt_start  = 1'b0;
        adv         = 1'b0;
        fin         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_ld    = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                we    = 1'b1;
                waddr = RF_AW'(r_ld);
                wdata = ld_val;
                if (r_ld == LD_LAST) begin
                    o_q_ready = 1'b1;
                    n_last    = i_q_data[DW-1];
                    n_pc      = '0;
                    n_state   = S_FETCH;
                end else begin
                    n_ld = r_ld + 5'd1;
                end
            end
            S_FETCH: begin
                n_busy  = 1'b0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (uop.opc)
                    OP_SUB: begin
                        we    = 1'b1;
                        wdata = sat_sub(rd_a, rd_b);
                        adv   = 1'b1;
                    end
                    OP_ADD: begin
                        we    = 1'b1;
                        wdata = sat_add(rd_a, rd_b);
                        adv   = 1'b1;
                    end
                    OP_MUL, OP_MADD, OP_MSUB: begin
                        if (!r_busy) begin
                            mul_start = 1'b1;
                            n_busy    = 1'b1;
                        end else if (mul_done) begin
                            n_acc = mac;
                            we    = 1'b1;
                            adv   = 1'b1;
                        end
                    end
                    OP_DIV: begin
                        if (!r_busy) begin
                            div_start = 1'b1;
                            n_busy    = 1'b1;
                        end else if (div_done) begin
                            n_acc = div_q;
                            we    = 1'b1;
                            wdata = div_q;
                            adv   = 1'b1;
                        end
                    end
                    OP_BRNEG: begin
                        adv = r_acc[QW-1];
                        fin = !r_acc[QW-1];
                    end
                    OP_BRNNEG: begin
                        adv = !r_acc[QW-1];
                        fin = r_acc[QW-1];
                    end
                    OP_BRPOS: begin
                        adv = !r_acc[QW-1] && (r_acc != '0);
                        fin = !adv;
                    end
                    OP_CMP: begin
                        if ((rd_a > rd_b) && (rd_a < r_acc)
                            && (!r_any || ($unsigned(rd_a) < r_best))) begin
                            n_best = rd_a;
                            n_any  = 1'b1;
                        end
                        adv = 1'b1;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
                if (adv) begin
                    n_pc    = r_pc + 7'd1;
                    n_state = S_FETCH;
                end
                if (fin) begin
                    if (r_last) begin
                        sqrt_start = 1'b1;
                        n_state    = S_SQRT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SQRT: begin
                if (sqrt_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    n_hit       = r_any;
                    if (!r_any) begin
                        n_dist = '0;
                    end else if (|r_best[QW-1:QW-FRAC_BITS]) begin
                        n_dist = '1;
                    end else begin
                        n_dist = sqrt_r;
                    end
                    n_best  = '0;
                    n_any   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ld        <= '0;
            r_pc        <= '0;
            r_busy      <= 1'b0;
            r_last      <= 1'b0;
            r_best      <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ld        <= n_ld;
            r_pc        <= n_pc;
            r_busy      <= n_busy;
            r_last      <= n_last;
            r_best      <= n_best;
            r_any       <= n_any;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_hit  <= n_hit;
        r_dist <= n_dist;
    end

    assign o_res_valid = r_out_valid;
    assign o_hit_found = r_hit;
    assign o_hit_range = r_dist;

    a_load_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> i_q_valid)
        else $error("queue emptied during load");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && (!r_out_valid || i_res_ready) |=> r_out_valid)
        else $error("result not registered on emit");

    a_best_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_best == '0))
        else $error("best distance set without a hit");

    a_mul_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_EXEC) && r_busy)
        else $error("multiplier result outside an exec step");
endmodule
`default_nettype wire

// ===== verif/tb_ray_triangle_closest_hit_core.sv =====
`timescale 1ns / 1ps
module tb_ray_triangle_closest_hit_core;
    import rtc_pkg::*;

    localparam longint QMAX  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam int     UNIT  = 65536;
    localparam int     DRAIN = 800;

    typedef logic [2:0][63:0] v3_t;

    typedef struct packed {
        logic [8:0][31:0] crd;
        logic             last;
    } tri_item_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] rng;
    } run_result_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    rtc_tri_if tri_bus ();
    rtc_res_if res_bus ();

    ray_triangle_closest_hit_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tri      (tri_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tri_item_t   pending_tris[$];
    run_result_t run_result_q[$];
    tri_item_t   cur_tri;
    logic [31:0] ray_cfg [8];
    logic [63:0] best_sq;
    logic        any_hit;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    logic        pressure_on;
    logic        hold_done;
    int          hold_left;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic longint sat_q(logic signed [65:0] s);
        if (s > 66'sd4611686018427387903) return QMAX;
        if (s < -66'sd4611686018427387903) return -QMAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint q_add(longint a, longint b);
        return sat_q($signed({{2{a[63]}}, a}) + $signed({{2{b[63]}}, b}));
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return sat_q($signed({{2{a[63]}}, a}) - $signed({{2{b[63]}}, b}));
    endfunction

    function automatic longint signed_mag(logic [63:0] m, logic neg);
        if (m > 64'(QMAX)) m = 64'(QMAX);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint q_mul(longint x, longint y);
        logic [63:0]  a;
        logic [63:0]  b;
        logic [127:0] p;
        logic [63:0]  r;
        a = (x < 0) ? 64'(-x) : 64'(x);
        b = (y < 0) ? 64'(-y) : 64'(y);
        p = {64'b0, a} * {64'b0, b};
        r = (p[127:80] != 0) ? '1 : p[79:16];
        return signed_mag(r, (x < 0) != (y < 0));
    endfunction

    function automatic longint q_div(longint x, longint y);
        logic [63:0]  a;
        logic [63:0]  d;
        logic [127:0] q;
        a = (x < 0) ? 64'(-x) : 64'(x);
        d = (y < 0) ? 64'(-y) : 64'(y);
        if (d == 0) return 0;
        q = {48'b0, a, 16'b0} / {64'b0, d};
        return signed_mag((q[127:64] != 0) ? '1 : q[63:0], (x < 0) != (y < 0));
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] pw;
        res = 0;
        pw  = 64'd1 << 62;
        while (pw > x) pw = pw >> 2;
        while (pw != 0) begin
            if (x >= res + pw) begin
                x   = x - (res + pw);
                res = (res >> 1) + pw;
            end else begin
                res = res >> 1;
            end
            pw = pw >> 2;
        end
        return res;
    endfunction

    function automatic v3_t v_sub(v3_t a, v3_t b);
        v3_t r;
        for (int k = 0; k < 3; k++) r[k] = q_sub(a[k], b[k]);
        return r;
    endfunction

    function automatic v3_t v_cross(v3_t a, v3_t b);
        v3_t r;
        r[0] = q_sub(q_mul(a[1], b[2]), q_mul(a[2], b[1]));
        r[1] = q_sub(q_mul(a[2], b[0]), q_mul(a[0], b[2]));
        r[2] = q_sub(q_mul(a[0], b[1]), q_mul(a[1], b[0]));
        return r;
    endfunction

    function automatic longint v_dot(v3_t a, v3_t b);
        return q_add(q_add(q_mul(a[0], b[0]), q_mul(a[1], b[1])), q_mul(a[2], b[2]));
    endfunction

    function automatic logic inside_edge(v3_t f, v3_t t, v3_t h, v3_t n);
        return v_dot(v_cross(v_sub(t, f), v_sub(h, f)), n) > 0;
    endfunction

    function automatic v3_t vec_of(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        v3_t r;
        r[0] = {{32{x[31]}}, x};
        r[1] = {{32{y[31]}}, y};
        r[2] = {{32{z[31]}}, z};
        return r;
    endfunction

    // update the run state for one triangle; returns 1 when the run closes
    function automatic logic trace_triangle(tri_item_t it, output run_result_t r);
        v3_t    va, vb, vc, org, dir, n, h;
        longint den, num, t, d2, lo2, hi2;
        va  = vec_of(it.crd[0], it.crd[1], it.crd[2]);
        vb  = vec_of(it.crd[3], it.crd[4], it.crd[5]);
        vc  = vec_of(it.crd[6], it.crd[7], it.crd[8]);
        org = vec_of(ray_cfg[0], ray_cfg[1], ray_cfg[2]);
        dir = vec_of(ray_cfg[3], ray_cfg[4], ray_cfg[5]);
        n   = v_cross(v_sub(vb, va), v_sub(vc, va));
        den = v_dot(n, dir);
        if (den < 0) begin
            num = v_dot(v_sub(org, va), n);
            t   = q_div(-num, den);
            if (t >= 0) begin
                for (int k = 0; k < 3; k++) h[k] = q_add(org[k], q_mul(t, dir[k]));
                if (inside_edge(va, vb, h, n) && inside_edge(vb, vc, h, n) &&
                    inside_edge(vc, va, h, n)) begin
                    d2  = v_dot(v_sub(org, h), v_sub(org, h));
                    lo2 = q_mul({33'b0, ray_cfg[6][30:0]}, {33'b0, ray_cfg[6][30:0]});
                    hi2 = q_mul({33'b0, ray_cfg[7][30:0]}, {33'b0, ray_cfg[7][30:0]});
                    if (d2 > lo2 && d2 < hi2 && (!any_hit || 64'(d2) < best_sq)) begin
                        best_sq = 64'(d2);
                        any_hit = 1'b1;
                    end
                end
            end
        end
        r = '0;
        if (!it.last) return 1'b0;
        r.hit = any_hit;
        if (any_hit) begin
            r.rng = (best_sq[63:48] != 0) ? '1 : 32'(isqrt(best_sq << 16));
        end
        best_sq = 0;
        any_hit = 1'b0;
        return 1'b1;
    endfunction

    // driver
    always @(posedge i_clk) begin
        run_result_t r;
        if (!i_rst_n) begin
            tri_bus.valid <= 1'b0;
        end else if (!tri_bus.valid || tri_bus.ready) begin
            if (tri_bus.valid && trace_triangle(cur_tri, r)) run_result_q.push_back(r);
            if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_tri = pending_tris.pop_front();
                tri_bus.valid         <= 1'b1;
                tri_bus.a_x           <= cur_tri.crd[0];
                tri_bus.a_y           <= cur_tri.crd[1];
                tri_bus.a_z           <= cur_tri.crd[2];
                tri_bus.b_x           <= cur_tri.crd[3];
                tri_bus.b_y           <= cur_tri.crd[4];
                tri_bus.b_z           <= cur_tri.crd[5];
                tri_bus.c_x           <= cur_tri.crd[6];
                tri_bus.c_y           <= cur_tri.crd[7];
                tri_bus.c_z           <= cur_tri.crd[8];
                tri_bus.last_triangle <= cur_tri.last;
            end else begin
                tri_bus.valid <= 1'b0;
            end
        end
    end

    // receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (pressure_on && !hold_done) begin
            hold_left <= 4000;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        run_result_t e;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
            if (res_bus.valid && res_bus.ready) begin
                if (run_result_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: hit %0b dist %h",
                                 res_bus.hit_found, res_bus.hit_range);
                end else begin
                    e = run_result_q.pop_front();
                    if (e.hit !== res_bus.hit_found || e.rng !== res_bus.hit_range) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp hit %0b dist %h, got hit %0b dist %h",
                                     e.hit, e.rng, res_bus.hit_found, res_bus.hit_range);
                    end
                end
            end
        end
    end

    task automatic push_tri(v3_t a, v3_t b, v3_t c, logic last);
        tri_item_t it;
        for (int k = 0; k < 3; k++) begin
            it.crd[k]     = a[k][31:0];
            it.crd[3 + k] = b[k][31:0];
            it.crd[6 + k] = c[k][31:0];
        end
        it.last = last;
        pending_tris.push_back(it);
    endtask

    function automatic v3_t pt(longint x, longint y, longint z);
        v3_t r;
        r[0] = x;
        r[1] = y;
        r[2] = z;
        return r;
    endfunction

    // triangle in plane z around the z axis; flip reverses the winding
    task automatic push_flat(longint z, logic flip, logic last);
        v3_t a, b, c;
        a = pt(-UNIT, -UNIT, z);
        b = pt(UNIT, -UNIT, z);
        c = pt(0, UNIT, z);
        if (flip) push_tri(a, c, b, last);
        else push_tri(a, b, c, last);
    endtask

    function automatic longint rnd_q(int units);
        return longint'($urandom_range(2 * units * UNIT)) - longint'(units) * UNIT;
    endfunction

    function automatic v3_t rnd_full();
        v3_t r;
        for (int k = 0; k < 3; k++) r[k] = {{32{1'b0}}, $urandom()};
        r[0] = {{32{r[0][31]}}, r[0][31:0]};
        r[1] = {{32{r[1][31]}}, r[1][31:0]};
        r[2] = {{32{r[2][31]}}, r[2][31:0]};
        return r;
    endfunction

    // triangle mostly placed around a point on the ray, else fully random or degenerate
    task automatic push_random(logic last);
        v3_t    p, e1, e2, a, b, c;
        int     sel;
        longint s;
        sel = $urandom_range(99);
        if (sel < 10) begin
            push_tri(rnd_full(), rnd_full(), rnd_full(), last);
        end else if (sel < 15) begin
            a = rnd_full();
            push_tri(a, a, a, last);
        end else begin
            s = $urandom_range(40);
            for (int k = 0; k < 3; k++) begin
                p[k]  = longint'($signed(ray_cfg[k])) + s * longint'($signed(ray_cfg[3 + k]));
                e1[k] = rnd_q(8);
                e2[k] = rnd_q(8);
                a[k]  = p[k] + e1[k];
                b[k]  = p[k] + e2[k];
                c[k]  = p[k] - e1[k] - e2[k] + rnd_q(1);
            end
            if ($urandom_range(3) == 0) push_tri(a, c, b, last);
            else push_tri(a, b, c, last);
        end
    endtask

    task automatic wait_idle();
        while (pending_tris.size() != 0 || tri_bus.valid || run_result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                             logic [31:0] near_v, logic [31:0] far_v);
        logic [31:0] v [8];
        v = '{ox, oy, oz, dx, dy, dz, near_v, far_v};
        for (int i = 0; i < 8; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= v[i];
            ray_cfg[i] = v[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int n_left;
        int run_len;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_ORG_X;
        i_cfg_data     = '0;
        tri_bus.valid  = 1'b0;
        tri_bus.a_x    = '0;
        tri_bus.a_y    = '0;
        tri_bus.a_z    = '0;
        tri_bus.b_x    = '0;
        tri_bus.b_y    = '0;
        tri_bus.b_z    = '0;
        tri_bus.c_x    = '0;
        tri_bus.c_y    = '0;
        tri_bus.c_z    = '0;
        tri_bus.last_triangle = 1'b0;
        res_bus.ready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        pressure_on    = 1'b0;
        best_sq        = 0;
        any_hit        = 1'b0;
        for (int i = 0; i < 8; i++) ray_cfg[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_ray(0, 0, 0, 0, 0, -UNIT, 0, 32'h7FFF_FFFF);
        push_flat(-5 * UNIT, 1'b0, 1'b0);
        push_flat(-8 * UNIT, 1'b1, 1'b1);
        push_tri(pt(UNIT, 2, 3), pt(UNIT, 2, 3), pt(UNIT, 2, 3), 1'b1);
        push_flat(5 * UNIT, 1'b0, 1'b1);
        push_flat(-3 * UNIT, 1'b0, 1'b0);
        push_flat(-3 * UNIT, 1'b0, 1'b1);
        push_flat(-1, 1'b0, 1'b1);
        push_flat(-30000 * UNIT, 1'b0, 1'b1);
        push_tri(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                 pt(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648),
                 pt(32'h5555_5555, -64'sd1431655766, 32'h5555_5555), 1'b0);
        push_tri(pt(-64'sd2147483648, 32'h7FFF_FFFF, 0),
                 pt(32'h7FFF_FFFF, -64'sd2147483648, 0),
                 pt(0, 0, -64'sd2147483648), 1'b1);
        push_tri(pt(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648),
                 pt(32'h7FFF_FFFF, -64'sd2147483648, -64'sd2147483648),
                 pt(-64'sd2147483648, 32'h7FFF_FFFF, -64'sd2147483648), 1'b1);
        wait_idle();

        write_ray(0, 0, 0, 0, 0, -UNIT, 4 * UNIT, 6 * UNIT);
        push_flat(-3 * UNIT, 1'b0, 1'b0);
        push_flat(-5 * UNIT, 1'b0, 1'b0);
        push_flat(-7 * UNIT, 1'b0, 1'b1);
        push_flat(-4 * UNIT, 1'b0, 1'b1);
        wait_idle();

        write_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 0);
        push_tri(rnd_full(), rnd_full(), rnd_full(), 1'b0);
        push_random(1'b1);
        wait_idle();

        for (int ph = 0; ph < 30; ph++) begin
            write_ray(32'(rnd_q(64)), 32'(rnd_q(64)), 32'(rnd_q(64)),
                      32'(rnd_q(4)), 32'(rnd_q(4)), 32'(rnd_q(4)),
                      ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(20 * UNIT),
                      ($urandom_range(4) < 2) ? 32'h7FFF_FFFF : $urandom_range(200 * UNIT));
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            if (ph == 4) begin
                send_idle_pct = 0;
                pressure_on   = 1'b1;
            end
            n_left = 45;
            while (n_left > 0) begin
                run_len = $urandom_range(1, 8);
                if (run_len > n_left) run_len = n_left;
                for (int i = 0; i < run_len; i++) push_random(i == run_len - 1);
                n_left = n_left - run_len;
            end
            wait_idle();
        end

        if (mismatches == 0 && run_result_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rtc_pkg.sv
rtl/rtc_tri_if.sv
rtl/rtc_res_if.sv
rtl/rtc_ram.sv
rtl/rtc_front.sv
rtl/rtc_mul.sv
rtl/rtc_div.sv
rtl/rtc_sqrt.sv
rtl/rtc_back.sv
rtl/ray_triangle_closest_hit_core.sv
verif/tb_ray_triangle_closest_hit_core.sv
